[rtl/drt_pkg.sv]
package drt_pkg;

   localparam int LOCAL_ENTRIES_DEF  = 1024;
   localparam int SUBNET_ENTRIES_DEF = 64;
   localparam int HOST_ID_BYTES_DEF  = 5;

   localparam logic [2:0] OP_ADDR_REQ = 3'd0;
   localparam logic [2:0] OP_RELEASE  = 3'd1;
   localparam logic [2:0] OP_GW_REG   = 3'd2;
   localparam logic [2:0] OP_ROUTE    = 3'd3;

   localparam logic [2:0] ST_ACK    = 3'd0;
   localparam logic [2:0] ST_NACK   = 3'd1;
   localparam logic [2:0] ST_GRANT  = 3'd2;
   localparam logic [2:0] ST_ROUTED = 3'd3;
   localparam logic [2:0] ST_DROP   = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [39:0] host_id;
      logic [5:0]  gateway_subnet;
      logic [15:0] dest_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] granted_addr;
      logic [39:0] dest_host;
      logic        via_gateway;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LOOKUP,
      S_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic scan;
      logic lookup;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic scan_done;
   } dp_status_type;

endpackage

[rtl/drt_ram.sv]
module drt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic [AW-1:0]    addr,
   input  logic             we,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/drt_ctrl.sv]
module drt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            op,
   input  drt_pkg::dp_status_type dp_status,
   output drt_pkg::ctl_cmd_type  cmd,
   output logic                  busy
);
   import drt_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (dp_status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               unique case (op) inside
                  OP_ADDR_REQ, OP_RELEASE: state_in = S_SCAN;
                  OP_ROUTE:                state_in = S_LOOKUP;
                  default:                 state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            if (dp_status.scan_done) state_in = S_FINISH;
         end
         S_LOOKUP: state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_CLEAR:  cmd.clr = 1'b1;
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_SCAN:   cmd.scan   = 1'b1;
         S_LOOKUP: cmd.lookup = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

endmodule

[rtl/drt_datapath.sv]
module drt_datapath #(
   parameter int LOCAL_ENTRIES  = drt_pkg::LOCAL_ENTRIES_DEF,
   parameter int SUBNET_ENTRIES = drt_pkg::SUBNET_ENTRIES_DEF,
   parameter int HOST_ID_BYTES  = drt_pkg::HOST_ID_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  drt_pkg::ctl_cmd_type   cmd,
   input  drt_pkg::req_type       req_item,
   input  logic                   csr_we,
   input  logic [5:0]             csr_wdata,
   output drt_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   output drt_pkg::rsp_type       rsp_item
);
   import drt_pkg::*;

   localparam int LB = $clog2(LOCAL_ENTRIES);
   localparam int GW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;
   localparam int HW = (HOST_ID_BYTES * 8 > 40) ? 40 : HOST_ID_BYTES * 8;

   logic [5:0]    subnet_ff;
   req_type       req_ff;
   logic [LB-1:0] clr_idx_ff, clr_idx_in;
   logic [LB:0]   scan_idx_ff, scan_idx_in;
   logic          pend_ff, pend_in;
   logic [LB-1:0] pend_idx_ff, pend_idx_in;
   logic          hit_ff, hit_in;
   logic [LB-1:0] hit_idx_ff, hit_idx_in;
   logic [SUBNET_ENTRIES-1:0] gw_vld_ff, gw_vld_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [HW-1:0] host_m;
   logic [LB-1:0] l_addr;
   logic          l_we, l_re;
   logic [HW:0]   l_wdata, l_rdata;
   logic [GW-1:0] g_addr;
   logic          g_we, g_re;
   logic [HW-1:0] g_rdata;
   logic          match;
   logic [15:0]   sub16, gsub16;
   logic [LB-1:0] loc;
   logic          loc_ok, gw_ok, gsub_ok;
   logic [31:0]   grant_full;

   assign host_m = req_ff.host_id[HW-1:0];
   assign sub16  = req_ff.dest_addr >> LB;
   assign loc    = req_ff.dest_addr[LB-1:0];
   assign loc_ok = 17'(loc) < 17'(LOCAL_ENTRIES);
   assign gw_ok  = 17'(sub16) < 17'(SUBNET_ENTRIES);
   assign gsub16 = 16'(req_ff.gateway_subnet);
   assign gsub_ok = 17'(gsub16) < 17'(SUBNET_ENTRIES);
   assign grant_full = (32'(subnet_ff) << LB) | 32'(hit_idx_ff);

   assign match = (req_ff.op == OP_ADDR_REQ) ? !l_rdata[HW]
                : (l_rdata[HW] && (l_rdata[HW-1:0] == host_m));

   assign dp_status.clr_done  = clr_idx_ff == LB'(LOCAL_ENTRIES - 1);
   assign dp_status.scan_done = pend_ff && (match || pend_idx_ff == LB'(LOCAL_ENTRIES - 1));

   always_comb begin
      l_addr  = hit_idx_ff;
      l_we    = 1'b0;
      l_re    = 1'b0;
      l_wdata = '0;
      if (cmd.clr) begin
         l_addr = clr_idx_ff;
         l_we   = 1'b1;
      end else if (cmd.scan) begin
         l_addr = scan_idx_ff[LB-1:0];
         l_re   = 1'b1;
      end else if (cmd.lookup) begin
         l_addr = loc;
         l_re   = 1'b1;
      end else if (cmd.finish && hit_ff) begin
         if (req_ff.op == OP_ADDR_REQ) begin
            l_we    = 1'b1;
            l_wdata = {1'b1, host_m};
         end else if (req_ff.op == OP_RELEASE) begin
            l_we = 1'b1;
         end
      end
   end

   always_comb begin
      g_addr = gsub16[GW-1:0];
      g_re   = 1'b0;
      g_we   = 1'b0;
      if (cmd.lookup) begin
         g_addr = sub16[GW-1:0];
         g_re   = 1'b1;
      end else if (cmd.finish && req_ff.op == OP_GW_REG && gsub_ok
                   && !gw_vld_ff[gsub16[GW-1:0]]) begin
         g_we = 1'b1;
      end
   end

   drt_ram #(.WIDTH(HW + 1), .DEPTH(LOCAL_ENTRIES), .AW(LB)) u_local_ram (
      .clock (clock),
      .addr  (l_addr),
      .we    (l_we),
      .wdata (l_wdata),
      .re    (l_re),
      .rdata (l_rdata)
   );

   drt_ram #(.WIDTH(HW), .DEPTH(SUBNET_ENTRIES), .AW(GW)) u_gw_ram (
      .clock (clock),
      .addr  (g_addr),
      .we    (g_we),
      .wdata (host_m),
      .re    (g_re),
      .rdata (g_rdata)
   );

   always_comb begin
      clr_idx_in  = cmd.clr ? clr_idx_ff + 1'b1 : clr_idx_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      gw_vld_in   = gw_vld_ff;
      if (cmd.load) begin
         scan_idx_in = (LB + 1)'(1);
         pend_in     = 1'b0;
         hit_in      = 1'b0;
      end else if (cmd.scan) begin
         pend_in     = scan_idx_ff < (LB + 1)'(LOCAL_ENTRIES);
         pend_idx_in = scan_idx_ff[LB-1:0];
         if (pend_in) scan_idx_in = scan_idx_ff + 1'b1;
         if (pend_ff && match) begin
            hit_in     = 1'b1;
            hit_idx_in = pend_idx_ff;
         end
      end
      if (g_we) gw_vld_in[gsub16[GW-1:0]] = 1'b1;
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ST_ACK;
      case (req_ff.op)
         OP_ADDR_REQ: begin
            if (hit_ff) begin
               rsp_in.status       = ST_GRANT;
               rsp_in.granted_addr = grant_full[15:0];
            end else begin
               rsp_in.status = ST_NACK;
            end
         end
         OP_RELEASE: rsp_in.status = hit_ff ? ST_ACK : ST_NACK;
         OP_GW_REG:  rsp_in.status = g_we ? ST_ACK : ST_NACK;
         OP_ROUTE: begin
            rsp_in.status = ST_DROP;
            if (sub16 == 16'(subnet_ff)) begin
               if (loc_ok && l_rdata[HW]) begin
                  rsp_in.status    = ST_ROUTED;
                  rsp_in.dest_host = 40'(l_rdata[HW-1:0]);
               end
            end else if (gw_ok && gw_vld_ff[sub16[GW-1:0]]) begin
               rsp_in.status      = ST_ROUTED;
               rsp_in.dest_host   = 40'(g_rdata);
               rsp_in.via_gateway = 1'b1;
            end
         end
         default: rsp_in.status = ST_ACK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subnet_ff    <= 6'd1;
         clr_idx_ff   <= '0;
         gw_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (csr_we) subnet_ff <= csr_wdata;
         clr_idx_ff   <= clr_idx_in;
         gw_vld_ff    <= gw_vld_in;
         rsp_valid_ff <= cmd.finish;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.finish) rsp_ff <= rsp_in;
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // entry zero is never handed out
   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_GRANT |-> rsp_ff.granted_addr[LB-1:0] != '0)
      else $error("granted local entry zero");

   a_host_only_routed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_ROUTED |-> rsp_ff.dest_host == '0
      && !rsp_ff.via_gateway)
      else $error("destination host on unrouted transfer");

   a_scan_hit_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.scan && dp_status.scan_done |-> pend_ff)
      else $error("scan finished without a compare");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

endmodule

[rtl/debug_address_router_table.sv]
// Route data: after accept, S_LOOKUP does one local/gateway RAM read, then S_FINISH registers the response strobe.
// Gateway register and other management: S_FINISH follows accept directly, then the response strobe.
// Address request and release walk the local RAM one entry a cycle in S_SCAN, then pass S_FINISH.
// Next transfer may be accepted in the cycle the response strobe is shown; receiver cannot stall.
// Reset is synchronous; afterwards busy stays high in S_CLEAR while the
// local table is cleared (csr writes are taken meanwhile).
module debug_address_router_table #(
   parameter int LOCAL_ENTRIES  = drt_pkg::LOCAL_ENTRIES_DEF,
   parameter int SUBNET_ENTRIES = drt_pkg::SUBNET_ENTRIES_DEF,
   parameter int HOST_ID_BYTES  = drt_pkg::HOST_ID_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  drt_pkg::req_type req_item,
   output logic             rsp_valid,
   output drt_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);
   import drt_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_item.op),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   drt_datapath #(
      .LOCAL_ENTRIES  (LOCAL_ENTRIES),
      .SUBNET_ENTRIES (SUBNET_ENTRIES),
      .HOST_ID_BYTES  (HOST_ID_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[tb/testbench.sv]
module testbench;
   import drt_pkg::*;

   localparam int LOCAL_N  = LOCAL_ENTRIES_DEF;
   localparam int SUBNET_N = SUBNET_ENTRIES_DEF;
   localparam int LB       = $clog2(LOCAL_N);
   localparam logic [2:0] OP_OTHER = 3'd4;
   localparam longint CYCLE_LIMIT = 64'd40000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_item = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we = 1'b0;
   logic [5:0]       csr_wdata = '0;

   debug_address_router_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        loc_valid [LOCAL_N];
   logic [39:0] loc_host  [LOCAL_N];
   logic        gw_valid  [SUBNET_N];
   logic [39:0] gw_host   [SUBNET_N];
   logic [5:0]  own_subnet;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      gap = 0;
   longint  cycles = 0;

   function automatic rsp_type route_item(req_type r);
      rsp_type o;
      logic [15:0] sub;
      logic [15:0] lo;
      o = '0;
      case (r.op)
         OP_ADDR_REQ: begin
            o.status = ST_NACK;
            for (int i = 1; i < LOCAL_N; i++) begin
               if (!loc_valid[i]) begin
                  loc_valid[i] = 1'b1;
                  loc_host[i]  = r.host_id;
                  o.granted_addr = 16'((32'(own_subnet) << LB) | i);
                  o.status = ST_GRANT;
                  break;
               end
            end
         end
         OP_RELEASE: begin
            o.status = ST_NACK;
            for (int i = 1; i < LOCAL_N; i++) begin
               if (loc_valid[i] && loc_host[i] == r.host_id) begin
                  loc_valid[i] = 1'b0;
                  loc_host[i]  = '0;
                  o.status = ST_ACK;
                  break;
               end
            end
         end
         OP_GW_REG: begin
            if (r.gateway_subnet >= SUBNET_N || gw_valid[r.gateway_subnet]) begin
               o.status = ST_NACK;
            end else begin
               gw_valid[r.gateway_subnet] = 1'b1;
               gw_host[r.gateway_subnet]  = r.host_id;
               o.status = ST_ACK;
            end
         end
         OP_ROUTE: begin
            sub = r.dest_addr >> LB;
            lo  = r.dest_addr & 16'((1 << LB) - 1);
            o.status = ST_DROP;
            if (sub == 16'(own_subnet)) begin
               if (lo < LOCAL_N && loc_valid[lo]) begin
                  o.dest_host = loc_host[lo];
                  o.status = ST_ROUTED;
               end
            end else if (sub < SUBNET_N && gw_valid[sub]) begin
               o.dest_host = gw_host[sub];
               o.via_gateway = 1'b1;
               o.status = ST_ROUTED;
            end
         end
         default: o.status = ST_ACK;
      endcase
      return o;
   endfunction

   function automatic logic [15:0] pick_dest();
      logic [15:0] a;
      logic [5:0]  s;
      a = 16'($urandom);
      case ($urandom_range(0, 3))
         0: a = (16'(own_subnet) << LB) | 16'($urandom_range(0, 40));
         1: begin
            s = 6'($urandom_range(0, 63));
            a = (16'(s) << LB) | 16'($urandom);
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [39:0] pick_host();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return 40'($urandom_range(1, 12));
         default: return {8'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic queue_item(logic [2:0] op, logic [39:0] h, logic [5:0] g, logic [15:0] d);
      req_type r;
      r.op = op; r.host_id = h; r.gateway_subnet = g; r.dest_addr = d;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (LOCAL_N + 20) @(posedge clock);
   endtask

   task automatic set_subnet(logic [5:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      own_subnet = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // transfer taken at this edge
         expected_rsps.push_back(route_item(req_item));
         if (pending_reqs.size() != 0 && $urandom_range(0, 3) != 0) begin
            req_item <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
         end
      end else if (!start) begin
         if (gap > 0) begin
            gap = gap - 1;
         end else if (pending_reqs.size() != 0) begin
            req_item <= pending_reqs.pop_front();
            start    <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected transfer %p", rsp_item);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.status !== e.status || rsp_item.granted_addr !== e.granted_addr ||
                rsp_item.dest_host !== e.dest_host || rsp_item.via_gateway !== e.via_gateway)
            begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp_item);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [5:0] subnets [4];
      logic [2:0] op;
      int n;
      subnets = '{6'd1, 6'd0, 6'd63, 6'd0};
      subnets[3] = 6'($urandom_range(2, 62));
      for (int i = 0; i < LOCAL_N; i++) begin
         loc_valid[i] = 1'b0; loc_host[i] = '0;
      end
      for (int i = 0; i < SUBNET_N; i++) begin
         gw_valid[i] = 1'b0; gw_host[i] = '0;
      end
      own_subnet = 6'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (LOCAL_N + 10) @(posedge clock);

      // directed
      queue_item(OP_ROUTE, '0, '0, 16'h0400);
      queue_item(OP_RELEASE, 40'd5, '0, '0);
      queue_item(OP_ADDR_REQ, '1, '0, '0);
      queue_item(OP_ADDR_REQ, '0, '0, '0);
      queue_item(OP_ADDR_REQ, '1, '0, '0);
      queue_item(OP_ROUTE, '0, '0, 16'h0401);
      queue_item(OP_ROUTE, '0, '0, 16'h0403);
      queue_item(OP_RELEASE, '1, '0, '0);
      queue_item(OP_ROUTE, '0, '0, 16'h0401);
      queue_item(OP_GW_REG, 40'hA5A5A5A5A5, 6'd63, '0);
      queue_item(OP_GW_REG, 40'h1, 6'd63, '0);
      queue_item(OP_GW_REG, 40'h2, 6'd0, '0);
      queue_item(OP_ROUTE, '0, '0, 16'hFFFF);
      queue_item(OP_ROUTE, '0, '0, 16'h0000);
      queue_item(OP_ROUTE, '0, '0, 16'h0800);
      queue_item(OP_OTHER, '1, '1, '1);
      queue_item(3'd5, '0, '0, '0);
      queue_item(3'd7, '1, '1, '1);
      queue_item(OP_ROUTE, '0, '0, 16'h07FF);
      drain();

      // fill the table to exercise the full case, then free the low hosts
      for (int i = 0; i < LOCAL_N; i++) queue_item(OP_ADDR_REQ, 40'(i), '0, '0);
      queue_item(OP_ROUTE, '0, '0, 16'h07FF);
      for (int i = 0; i < 64; i++) queue_item(OP_RELEASE, 40'(i), '0, '0);
      drain();

      for (int p = 0; p < 4; p++) begin
         set_subnet(subnets[p]);
         for (n = 0; n < 225; n++) begin
            op = 3'($urandom_range(0, 99) < 20 ? OP_ADDR_REQ :
                    $urandom_range(0, 99) < 25 ? OP_RELEASE :
                    $urandom_range(0, 99) < 20 ? OP_GW_REG :
                    $urandom_range(0, 99) < 85 ? OP_ROUTE : $urandom_range(4, 7));
            queue_item(op, pick_host(), 6'($urandom), pick_dest());
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
